// ----- sv/assert_macros.svh -----
// assertion helpers for the port-level checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge, skipped while in reset
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// same, but checked during reset as well
`define ASSERT_CLK_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- sv/tdw_pkg.sv -----
// ----------------------------------------------------------------------------
// tdw_pkg
// Types and constants for the transmit drain watchdog.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tdw_pkg;

   // field widths
   localparam int COUNT_W      = 24;
   localparam int RATE_W       = 24;
   localparam int BUDGET_W     = 18;
   localparam int THR_W        = 10;
   localparam int QUIET_W      = 12;
   localparam int TIMEOUT_W    = 20;
   localparam int DEBOUNCE_W   = 10;
   localparam int CSR_INDEX_W  = 2;
   localparam int CSR_DATA_W   = 20;

   // divider widths: pending * 1000, and the 9000 ms quiet constant
   localparam int EST_NUM_W    = COUNT_W + 10;
   localparam int QUIET_NUM_W  = 14;

   // item modes
   typedef enum logic [1:0] {
      MODE_BEGIN = 2'd0,
      MODE_TICK  = 2'd1,
      MODE_POLL  = 2'd2,
      MODE_RESET = 2'd3
   } mode_type;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_DRAIN_TIMEOUT = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DEBOUNCE      = 2'd1;

   // register reset values
   localparam logic [TIMEOUT_W-1:0]  DRAIN_TIMEOUT_RST = 20'd10000;
   localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RST      = 10'd50;

   // begin derivation constants
   localparam logic [TIMEOUT_W-1:0] BASE_MIN_MS   = 20'd3000;
   localparam logic [RATE_W-1:0]    RATE_FLOOR    = 24'd16;
   localparam logic [RATE_W-1:0]    RATE_DEFAULT  = 24'd32;
   localparam logic [9:0]           MS_PER_S      = 10'd1000;
   localparam logic [25:0]          GUARD_OFFSET  = 26'd1500;
   localparam logic [15:0]          GUARD_MIN     = 16'd5000;
   localparam logic [15:0]          GUARD_MAX     = 16'd45000;
   localparam logic [17:0]          BUDGET_MIN    = 18'd8000;
   localparam logic [17:0]          BUDGET_MAX    = 18'd180000;
   localparam logic [10:0]          THR_MIN       = 11'd96;
   localparam logic [10:0]          THR_MAX       = 11'd768;
   localparam logic [COUNT_W-1:0]   THR_SAT_BYTES = 24'd2304;
   localparam logic [23:0]          RECIP3        = 24'd2731;
   localparam int                   RECIP3_SHIFT  = 13;
   localparam logic [50:0]          RECIP5        = 51'd26843546;
   localparam int                   RECIP5_SHIFT  = 27;
   localparam logic [QUIET_NUM_W-1:0] QUIET_NUM   = 14'd9000;
   localparam logic [12:0]          QUIET_MIN     = 13'd600;
   localparam logic [12:0]          QUIET_MAX     = 13'd2500;

   // poll constants
   localparam logic [11:0]          STABLE_MIN    = 12'd180;
   localparam logic [11:0]          STABLE_MAX    = 12'd3000;
   localparam logic [17:0]          LIMIT_MIN     = 18'd3000;
   localparam logic [16:0]          STALL_MIN     = 17'd5000;
   localparam logic [16:0]          STALL_MAX     = 17'd45000;
   localparam logic [10:0]          HARD_MIN      = 11'd1024;

   // counter saturation
   localparam logic [17:0]          SAT18         = 18'h3ffff;
   localparam logic [11:0]          SAT12         = 12'hfff;

   typedef struct packed {
      mode_type             mode;
      logic [COUNT_W-1:0]   pending_bytes;
      logic [RATE_W-1:0]    effective_bps;
      logic [RATE_W-1:0]    wire_bps;
      logic [COUNT_W-1:0]   bytes_left;
      logic                 send_allowed;
   } req_type;

   typedef struct packed {
      logic                 can_finish;
      logic                 timed_out;
      logic                 drain_active;
      logic [BUDGET_W-1:0]  budget_ms;
      logic [THR_W-1:0]     near_threshold;
      logic [QUIET_W-1:0]   quiet_window_ms;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic exec_op;
      logic cap_begin;
      logic start_div;
      logic fin_begin;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic div_busy;
   } status_type;

endpackage

`default_nettype wire

// ----- sv/tx_drain_watchdog.sv -----
// ----------------------------------------------------------------------------
// tx_drain_watchdog
// Timeout and finish tracking for a draining serial transmit buffer.
// ----------------------------------------------------------------------------
//  channel | ports                           | transfer when
//  --------+---------------------------------+------------------------------
//  request | req_valid req_stall req_payload | req_valid && !req_stall
//  result  | rsp_valid rsp_stall rsp_payload | rsp_valid && !rsp_stall
//  config  | csr_write_en csr_index csr_wdata| csr_write_en
//
//  tick, poll and reset items finish on acceptance; the result is registered.
//  a begin item runs through capture, prepare, 34 steps of the
//  one-bit-per-cycle estimate divider, a step to see it idle, and finish.
//  one item is worked at a time; a stalled result holds off the next item.
//  synchronous reset clears the control and watchdog state; registers return to their defaults.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tx_drain_watchdog (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_stall,
   input  wire tdw_pkg::req_type                 req_payload,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_stall,
   output tdw_pkg::rsp_type                      rsp_payload,
   input  wire logic                             csr_write_en,
   input  wire logic [tdw_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [tdw_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   tdw_pkg::cmd_type    cmd;
   tdw_pkg::status_type status;

   tdw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_mode  (req_payload.mode),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .status    (status)
   );

   tdw_datapath u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .req          (req_payload),
      .rsp          (rsp_payload),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

endmodule

`default_nettype wire

// ----- sv/tdw_divider.sv -----
// ----------------------------------------------------------------------------
// tdw_divider
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tdw_divider #(
   parameter int NUM_W = 34,
   parameter int DEN_W = 24
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [NUM_W-1:0] num,
   input  wire logic [DEN_W-1:0] den,
   output logic                  busy,
   output logic [NUM_W-1:0]      quot,
   output logic                  rem_nz
);

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic [NUM_W-1:0] quot_ff, quot_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic [DEN_W:0]   trial;
   logic             fits;

   // one shift and trial subtract
   always_comb begin
      trial   = {rem_ff, quot_ff[NUM_W-1]};
      fits    = trial >= {1'b0, den_ff};
      quot_in = quot_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         quot_in = num;
         rem_in  = '0;
         cnt_in  = CNT_W'(NUM_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quot_in = {quot_ff[NUM_W-2:0], fits};
         rem_in  = fits ? DEN_W'(trial - {1'b0, den_ff}) : trial[DEN_W-1:0];
         cnt_in  = cnt_ff - 1'b1;
         busy_in = cnt_ff != CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      if (start) begin
         den_ff <= den;
      end
   end

   assign busy   = busy_ff;
   assign quot   = quot_ff;
   assign rem_nz = rem_ff != '0;

endmodule

`default_nettype wire

// ----- sv/tdw_datapath.sv -----
// ----------------------------------------------------------------------------
// tdw_datapath
// Watchdog state, begin derivation, poll evaluation and the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tdw_datapath (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire tdw_pkg::cmd_type                   cmd,
   output tdw_pkg::status_type                     status,
   input  wire tdw_pkg::req_type                   req,
   output tdw_pkg::rsp_type                        rsp,
   input  wire logic                               csr_write_en,
   input  wire logic [tdw_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [tdw_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   // configuration registers
   logic [tdw_pkg::TIMEOUT_W-1:0]  drain_timeout_ff;
   logic [tdw_pkg::DEBOUNCE_W-1:0] debounce_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         drain_timeout_ff <= tdw_pkg::DRAIN_TIMEOUT_RST;
         debounce_ff      <= tdw_pkg::DEBOUNCE_RST;
      end else if (csr_write_en) begin
         case (csr_index)
            tdw_pkg::CSR_DRAIN_TIMEOUT: drain_timeout_ff <= csr_wdata;
            tdw_pkg::CSR_DEBOUNCE:      debounce_ff <= csr_wdata[tdw_pkg::DEBOUNCE_W-1:0];
            default: ;
         endcase
      end
   end

   // begin capture: products, guard and threshold
   logic [tdw_pkg::COUNT_W-1:0]   pend_ff;
   logic [tdw_pkg::RATE_W-1:0]    eff_ff, wire_ff, wire5_ff;
   logic [tdw_pkg::EST_NUM_W-1:0] num_ff;
   logic [15:0]                   guard_ff, guard_in;
   logic [tdw_pkg::THR_W-1:0]     thr_cap_ff, thr_cap_in;
   logic [50:0]                   w5_prod;
   logic [25:0]                   guard_raw;
   logic [23:0]                   d3_prod;
   logic [10:0]                   third, thr_cl;

   always_comb begin
      w5_prod   = 51'(req.wire_bps) * tdw_pkg::RECIP5;
      guard_raw = {1'b0, req.pending_bytes, 1'b0} + tdw_pkg::GUARD_OFFSET;
      if (guard_raw < 26'(tdw_pkg::GUARD_MIN)) begin
         guard_in = tdw_pkg::GUARD_MIN;
      end else if (guard_raw > 26'(tdw_pkg::GUARD_MAX)) begin
         guard_in = tdw_pkg::GUARD_MAX;
      end else begin
         guard_in = guard_raw[15:0];
      end
      d3_prod = 24'(req.pending_bytes[11:0]) * tdw_pkg::RECIP3;
      third   = (req.pending_bytes >= tdw_pkg::THR_SAT_BYTES) ? tdw_pkg::THR_MAX
                : d3_prod[23:tdw_pkg::RECIP3_SHIFT];
      if (third < tdw_pkg::THR_MIN) begin
         thr_cl = tdw_pkg::THR_MIN;
      end else if (third > tdw_pkg::THR_MAX) begin
         thr_cl = tdw_pkg::THR_MAX;
      end else begin
         thr_cl = third;
      end
      thr_cap_in = (req.pending_bytes < 24'(thr_cl)) ? req.pending_bytes[tdw_pkg::THR_W-1:0]
                   : thr_cl[tdw_pkg::THR_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (cmd.cap_begin) begin
         pend_ff    <= req.pending_bytes;
         eff_ff     <= req.effective_bps;
         wire_ff    <= req.wire_bps;
         num_ff     <= tdw_pkg::EST_NUM_W'(req.pending_bytes) *
                       tdw_pkg::EST_NUM_W'(tdw_pkg::MS_PER_S);
         wire5_ff   <= w5_prod[tdw_pkg::RECIP5_SHIFT +: tdw_pkg::RATE_W];
         guard_ff   <= guard_in;
         thr_cap_ff <= thr_cap_in;
      end
   end

   // reference rates for the two divisions
   logic                       has_e, has_w;
   logic [tdw_pkg::RATE_W-1:0] eff_fl, wire4_fl, ref_rate, quiet_rate;

   always_comb begin
      has_e    = eff_ff > 24'd1;
      has_w    = wire_ff > 24'd1;
      eff_fl   = (eff_ff < tdw_pkg::RATE_FLOOR) ? tdw_pkg::RATE_FLOOR : eff_ff;
      wire4_fl = ((wire_ff >> 2) < tdw_pkg::RATE_FLOOR) ? tdw_pkg::RATE_FLOOR : (wire_ff >> 2);
      if (has_e && has_w) begin
         ref_rate = (wire_ff < eff_fl) ? wire_ff : eff_fl;
      end else if (has_e) begin
         ref_rate = eff_fl;
      end else if (has_w) begin
         ref_rate = wire4_fl;
      end else begin
         ref_rate = tdw_pkg::RATE_DEFAULT;
      end
      quiet_rate = (wire5_ff > eff_fl) ? wire5_ff : eff_fl;
   end

   logic                            est_busy, quiet_busy, est_rnz, quiet_rnz;
   logic [tdw_pkg::EST_NUM_W-1:0]   est_q;
   logic [tdw_pkg::QUIET_NUM_W-1:0] quiet_q;

   tdw_divider #(
      .NUM_W(tdw_pkg::EST_NUM_W),
      .DEN_W(tdw_pkg::RATE_W)
   ) u_est_div (
      .clock  (clock),
      .reset  (reset),
      .start  (cmd.start_div),
      .num    (num_ff),
      .den    (ref_rate),
      .busy   (est_busy),
      .quot   (est_q),
      .rem_nz (est_rnz)
   );

   tdw_divider #(
      .NUM_W(tdw_pkg::QUIET_NUM_W),
      .DEN_W(tdw_pkg::RATE_W)
   ) u_quiet_div (
      .clock  (clock),
      .reset  (reset),
      .start  (cmd.start_div),
      .num    (tdw_pkg::QUIET_NUM),
      .den    (quiet_rate),
      .busy   (quiet_busy),
      .quot   (quiet_q),
      .rem_nz (quiet_rnz)
   );

   assign status.div_busy = est_busy | quiet_busy;

   // budget and quiet window from the quotients
   logic [35:0]                     est_sum, budget_pick;
   logic [tdw_pkg::TIMEOUT_W-1:0]   base_ms;
   logic [tdw_pkg::BUDGET_W-1:0]    new_budget;
   logic [12:0]                     adaptive, deb6, quiet_pick;
   logic [tdw_pkg::QUIET_W-1:0]     new_quiet;

   always_comb begin
      est_sum     = 36'(est_q) + 36'(est_rnz) + 36'(guard_ff);
      base_ms     = (drain_timeout_ff < tdw_pkg::BASE_MIN_MS) ? tdw_pkg::BASE_MIN_MS
                    : drain_timeout_ff;
      budget_pick = (36'(base_ms) > est_sum) ? 36'(base_ms) : est_sum;
      if (budget_pick < 36'(tdw_pkg::BUDGET_MIN)) begin
         new_budget = tdw_pkg::BUDGET_MIN;
      end else if (budget_pick > 36'(tdw_pkg::BUDGET_MAX)) begin
         new_budget = tdw_pkg::BUDGET_MAX;
      end else begin
         new_budget = budget_pick[tdw_pkg::BUDGET_W-1:0];
      end
      adaptive   = 13'(quiet_q) + 13'(quiet_rnz);
      deb6       = 13'(debounce_ff) * 13'd6;
      quiet_pick = (adaptive > deb6) ? adaptive : deb6;
      if (quiet_pick < tdw_pkg::QUIET_MIN) begin
         new_quiet = tdw_pkg::QUIET_W'(tdw_pkg::QUIET_MIN);
      end else if (quiet_pick > tdw_pkg::QUIET_MAX) begin
         new_quiet = tdw_pkg::QUIET_W'(tdw_pkg::QUIET_MAX);
      end else begin
         new_quiet = quiet_pick[tdw_pkg::QUIET_W-1:0];
      end
   end

   // watchdog state
   logic                          active_ff, active_in;
   logic [tdw_pkg::BUDGET_W-1:0]  budget_ff, budget_in;
   logic [tdw_pkg::THR_W-1:0]     thr_ff, thr_in;
   logic [tdw_pkg::QUIET_W-1:0]   quiet_ff, quiet_in;
   logic [tdw_pkg::COUNT_W-1:0]   last_left_ff, last_left_in;
   logic                          last_valid_ff, last_valid_in;
   logic [17:0]                   drain_el_ff, drain_el_in;
   logic [17:0]                   prog_el_ff, prog_el_in;
   logic [11:0]                   stab_el_ff, stab_el_in;
   logic                          stab_valid_ff, stab_valid_in;

   // poll terms
   logic [11:0]                   deb4, stable_pick, stable_ms;
   logic [17:0]                   limit;
   logic [16:0]                   stall_ms;
   logic [10:0]                   hard_bytes, thr2;
   logic                          progress, near_quiet, cf, to;
   logic [tdw_pkg::COUNT_W-1:0]   b_left;

   always_comb begin
      deb4        = {debounce_ff, 2'b00};
      stable_pick = (quiet_ff > deb4) ? quiet_ff : deb4;
      if (stable_pick < tdw_pkg::STABLE_MIN) begin
         stable_ms = tdw_pkg::STABLE_MIN;
      end else if (stable_pick > tdw_pkg::STABLE_MAX) begin
         stable_ms = tdw_pkg::STABLE_MAX;
      end else begin
         stable_ms = stable_pick;
      end
      limit    = (budget_ff < tdw_pkg::LIMIT_MIN) ? tdw_pkg::LIMIT_MIN : budget_ff;
      if (limit[17:1] < tdw_pkg::STALL_MIN) begin
         stall_ms = tdw_pkg::STALL_MIN;
      end else if (limit[17:1] > tdw_pkg::STALL_MAX) begin
         stall_ms = tdw_pkg::STALL_MAX;
      end else begin
         stall_ms = limit[17:1];
      end
      thr2       = {thr_ff, 1'b0};
      hard_bytes = (thr2 > tdw_pkg::HARD_MIN) ? thr2 : tdw_pkg::HARD_MIN;
      b_left     = req.bytes_left;
      progress   = !last_valid_ff || (b_left < last_left_ff);

      active_in     = active_ff;
      budget_in     = budget_ff;
      thr_in        = thr_ff;
      quiet_in      = quiet_ff;
      last_left_in  = last_left_ff;
      last_valid_in = last_valid_ff;
      drain_el_in   = drain_el_ff;
      prog_el_in    = prog_el_ff;
      stab_el_in    = stab_el_ff;
      stab_valid_in = stab_valid_ff;
      near_quiet    = 1'b0;
      cf            = 1'b0;
      to            = 1'b0;

      if (cmd.exec_op) begin
         case (req.mode)
            tdw_pkg::MODE_TICK: begin
               if (drain_el_ff != tdw_pkg::SAT18) drain_el_in = drain_el_ff + 1'b1;
               if (prog_el_ff != tdw_pkg::SAT18) prog_el_in = prog_el_ff + 1'b1;
               if (stab_el_ff != tdw_pkg::SAT12) stab_el_in = stab_el_ff + 1'b1;
            end
            tdw_pkg::MODE_POLL: begin
               if (active_ff) begin
                  if (progress) begin
                     prog_el_in    = '0;
                     stab_valid_in = 1'b0;
                  end
                  last_left_in  = b_left;
                  last_valid_in = 1'b1;
                  near_quiet    = (thr_ff != '0) && (b_left <= 24'(thr_ff)) &&
                                  (prog_el_in >= 18'(stable_ms));
                  // stable window: open, check or clear
                  if (!req.send_allowed && b_left != '0) begin
                     stab_valid_in = 1'b0;
                  end else if (b_left == '0 || near_quiet) begin
                     if (!stab_valid_in) begin
                        stab_valid_in = 1'b1;
                        stab_el_in    = '0;
                     end else begin
                        cf = stab_el_ff >= stable_ms;
                     end
                  end else begin
                     stab_valid_in = 1'b0;
                  end
                  // stall on a large residual, or overall timeout
                  if (req.send_allowed && !cf) begin
                     to = ((b_left > 24'(hard_bytes)) && (prog_el_in > 18'(stall_ms))) ||
                          (drain_el_ff > limit);
                  end
               end
            end
            tdw_pkg::MODE_RESET: begin
               active_in     = 1'b0;
               budget_in     = '0;
               thr_in        = '0;
               quiet_in      = '0;
               last_left_in  = '0;
               last_valid_in = 1'b0;
            end
            default: ;
         endcase
      end

      // begin completes once both quotients are in
      if (cmd.fin_begin) begin
         active_in     = 1'b1;
         budget_in     = new_budget;
         thr_in        = thr_cap_ff;
         quiet_in      = new_quiet;
         last_left_in  = pend_ff;
         last_valid_in = 1'b1;
         drain_el_in   = '0;
         prog_el_in    = '0;
         stab_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff     <= 1'b0;
         budget_ff     <= '0;
         thr_ff        <= '0;
         quiet_ff      <= '0;
         last_left_ff  <= '0;
         last_valid_ff <= 1'b0;
         drain_el_ff   <= '0;
         prog_el_ff    <= '0;
         stab_el_ff    <= '0;
         stab_valid_ff <= 1'b0;
      end else begin
         active_ff     <= active_in;
         budget_ff     <= budget_in;
         thr_ff        <= thr_in;
         quiet_ff      <= quiet_in;
         last_left_ff  <= last_left_in;
         last_valid_ff <= last_valid_in;
         drain_el_ff   <= drain_el_in;
         prog_el_ff    <= prog_el_in;
         stab_el_ff    <= stab_el_in;
         stab_valid_ff <= stab_valid_in;
      end
   end

   // result register
   tdw_pkg::rsp_type rsp_ff;

   always_ff @(posedge clock) begin
      if (cmd.exec_op || cmd.fin_begin) begin
         rsp_ff.can_finish      <= cf;
         rsp_ff.timed_out       <= to;
         rsp_ff.drain_active    <= active_in;
         rsp_ff.budget_ms       <= budget_in;
         rsp_ff.near_threshold  <= thr_in;
         rsp_ff.quiet_window_ms <= quiet_in;
      end
   end

   assign rsp = rsp_ff;

endmodule

`default_nettype wire

// ----- sv/tdw_ctrl.sv -----
// ----------------------------------------------------------------------------
// tdw_ctrl
// Sequencer for the watchdog: accepts items, steps begin through the divide.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tdw_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   input  wire tdw_pkg::mode_type   req_mode,
   output logic                     req_stall,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output tdw_pkg::cmd_type         cmd,
   input  wire tdw_pkg::status_type status
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PREP,
      ST_DIV,
      ST_FIN
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free, take, accept;

   // output register free when empty or draining this cycle
   always_comb begin
      out_free      = !rsp_valid_ff || !rsp_stall;
      take          = (state_ff == ST_IDLE) && out_free;
      accept        = req_valid && take;
      cmd.exec_op   = accept && (req_mode != tdw_pkg::MODE_BEGIN);
      cmd.cap_begin = accept && (req_mode == tdw_pkg::MODE_BEGIN);
      cmd.start_div = state_ff == ST_PREP;
      cmd.fin_begin = (state_ff == ST_FIN) && out_free;
   end

   // next state and result valid
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (cmd.cap_begin) state_in = ST_PREP;
         ST_PREP: state_in = ST_DIV;
         ST_DIV:  if (!status.div_busy) state_in = ST_FIN;
         ST_FIN:  if (out_free) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
      if (cmd.exec_op || cmd.fin_begin) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = !take;
   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

// ----- sv/tdw_checker.sv -----
// ----------------------------------------------------------------------------
// tdw_assertions
// Port-level checks for the transmit drain watchdog.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module tdw_assertions (
   input wire logic                             clock,
   input wire logic                             reset,
   input wire logic                             req_valid,
   input wire logic                             req_stall,
   input wire tdw_pkg::req_type                 req_payload,
   input wire logic                             rsp_valid,
   input wire logic                             rsp_stall,
   input wire tdw_pkg::rsp_type                 rsp_payload
);

   // short-item transfer: anything but begin
   logic fast_xfer;
   assign fast_xfer = req_valid && !req_stall && req_payload.mode != tdw_pkg::MODE_BEGIN;

   // inactive result with flags or budget set
   logic idle_bad;
   assign idle_bad = rsp_payload.can_finish || rsp_payload.timed_out ||
                     rsp_payload.budget_ms != '0;

   // a stalled result stays offered
   `ASSERT_CLK(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid, "result dropped")

   // a short item yields a result right after its transfer
   `ASSERT_CLK(a_fast_rsp, clock, reset, fast_xfer |=> rsp_valid, "no result after short item")

   // finish and timeout never reported together
   `ASSERT_CLK(a_excl, clock, reset, rsp_valid |-> !(rsp_payload.can_finish && rsp_payload.timed_out), "finish and timeout both set")

   // an inactive watchdog reports nothing and holds no budget
   `ASSERT_CLK(a_idle_quiet, clock, reset, rsp_valid && !rsp_payload.drain_active |-> !idle_bad, "inactive result not clear")

endmodule

bind tx_drain_watchdog tdw_assertions u_tdw_assertions (.*);

`default_nettype wire

// ----- verif/tdw_checker.sv -----
// ----------------------------------------------------------------------------
// tdw_checker
// Watches the request, result and register ports of the drain watchdog,
// predicts every result from its own copy of the drain state and compares
// each result transfer field by field against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tdw_checker (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   input  wire logic                             req_stall,
   input  wire tdw_pkg::req_type                 req_payload,
   input  wire logic                             rsp_valid,
   input  wire logic                             rsp_stall,
   input  wire tdw_pkg::rsp_type                 rsp_payload,
   input  wire logic                             csr_write_en,
   input  wire logic [tdw_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [tdw_pkg::CSR_DATA_W-1:0]   csr_wdata,
   output int                                    error_count,
   output int                                    pending_count,
   output int                                    result_count,
   output int                                    finish_count,
   output int                                    timeout_count
);
   import tdw_pkg::*;

   // register copies
   logic [TIMEOUT_W-1:0]  drain_timeout;
   logic [DEBOUNCE_W-1:0] debounce;

   // drain state copy
   logic        drn_active;
   logic [17:0] drn_budget;
   logic [9:0]  drn_thr;
   logic [11:0] drn_quiet;
   logic [23:0] drn_last;
   logic        drn_last_ok;
   logic [17:0] drain_ms;
   logic [17:0] progress_ms;
   logic [11:0] stable_ms_cnt;
   logic        stable_open;

   rsp_type expected_results[$];

   function automatic longint umax(longint a, longint b);
      return a > b ? a : b;
   endfunction

   function automatic longint umin(longint a, longint b);
      return a < b ? a : b;
   endfunction

   function automatic longint clampv(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   // advance the predicted state by one item, return the expected result
   task automatic predict_watchdog(input req_type r, output rsp_type res);
      longint p, e, w, b, rate, est, guard, qref, stab, lim, hard, stall;
      logic cf, to, near_ok, quiet_ok;
      p = r.pending_bytes;
      e = r.effective_bps;
      w = r.wire_bps;
      b = r.bytes_left;
      cf = 0;
      to = 0;
      case (r.mode)
         MODE_BEGIN: begin
            if (e > 1 && w > 1) rate = umin(w, umax(16, e));
            else if (e > 1) rate = umax(16, e);
            else if (w > 1) rate = umax(16, w / 4);
            else rate = 32;
            est = (p * 1000 + rate - 1) / rate;
            guard = clampv(1500 + 2 * p, 5000, 45000);
            drn_budget = clampv(umax(umax(3000, drain_timeout), est + guard), 8000, 180000);
            drn_thr = (p == 0) ? 0 : umin(p, clampv(p / 3, 96, 768));
            qref = umax(umax(16, e), w / 5);
            drn_quiet = clampv(umax((9000 + qref - 1) / qref, debounce * 6), 600, 2500);
            drn_active = 1;
            drn_last = p;
            drn_last_ok = 1;
            drain_ms = 0;
            progress_ms = 0;
            stable_open = 0;
         end
         MODE_TICK: begin
            if (drain_ms != SAT18) drain_ms++;
            if (progress_ms != SAT18) progress_ms++;
            if (stable_ms_cnt != SAT12) stable_ms_cnt++;
         end
         MODE_POLL: begin
            if (drn_active) begin
               stab = clampv(umax(drn_quiet, debounce * 4), 180, 3000);
               if (!drn_last_ok || b < drn_last) begin
                  progress_ms = 0;
                  stable_open = 0;
               end
               drn_last = b;
               drn_last_ok = 1;
               near_ok = drn_thr > 0 && b <= drn_thr;
               quiet_ok = progress_ms >= stab;
               if (!r.send_allowed && b > 0) begin
                  stable_open = 0;
               end else if (b > 0 && !(near_ok && quiet_ok)) begin
                  stable_open = 0;
               end else if (!stable_open) begin
                  stable_open = 1;
                  stable_ms_cnt = 0;
               end else begin
                  cf = stable_ms_cnt >= stab;
               end
               if (r.send_allowed && !cf) begin
                  lim = umax(3000, drn_budget);
                  hard = umax(drn_thr * 2, 1024);
                  stall = clampv(lim / 2, 5000, 45000);
                  if (b > 0 && b > hard && progress_ms > stall) to = 1;
                  else to = drain_ms > lim;
               end
            end
         end
         default: begin
            drn_active = 0;
            drn_budget = 0;
            drn_thr = 0;
            drn_quiet = 0;
            drn_last = 0;
            drn_last_ok = 0;
         end
      endcase
      res.can_finish = cf;
      res.timed_out = to;
      res.drain_active = drn_active;
      res.budget_ms = drn_budget;
      res.near_threshold = drn_thr;
      res.quiet_window_ms = drn_quiet;
   endtask

   // predict on request transfers, compare on result transfers
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         drain_timeout = DRAIN_TIMEOUT_RST;
         debounce = DEBOUNCE_RST;
         drn_active = 0; drn_budget = 0; drn_thr = 0; drn_quiet = 0;
         drn_last = 0; drn_last_ok = 0; drain_ms = 0; progress_ms = 0;
         stable_ms_cnt = 0; stable_open = 0;
         expected_results.delete();
      end else begin
         if (csr_write_en) begin
            if (csr_index == CSR_DRAIN_TIMEOUT) drain_timeout = csr_wdata[TIMEOUT_W-1:0];
            else if (csr_index == CSR_DEBOUNCE) debounce = csr_wdata[DEBOUNCE_W-1:0];
         end
         if (req_valid && !req_stall) begin
            predict_watchdog(req_payload, want);
            expected_results.push_back(want);
         end
         if (rsp_valid && !rsp_stall) begin
            result_count++;
            if (rsp_payload.can_finish) finish_count++;
            if (rsp_payload.timed_out) timeout_count++;
            if (expected_results.size() == 0) begin
               report_mismatch("unexpected result", 1, 0);
            end else begin
               want = expected_results.pop_front();
               if (rsp_payload.can_finish != want.can_finish)
                  report_mismatch("can_finish", rsp_payload.can_finish, want.can_finish);
               if (rsp_payload.timed_out != want.timed_out)
                  report_mismatch("timed_out", rsp_payload.timed_out, want.timed_out);
               if (rsp_payload.drain_active != want.drain_active)
                  report_mismatch("drain_active", rsp_payload.drain_active, want.drain_active);
               if (rsp_payload.budget_ms != want.budget_ms)
                  report_mismatch("budget_ms", rsp_payload.budget_ms, want.budget_ms);
               if (rsp_payload.near_threshold != want.near_threshold)
                  report_mismatch("near_threshold", rsp_payload.near_threshold,
                                  want.near_threshold);
               if (rsp_payload.quiet_window_ms != want.quiet_window_ms)
                  report_mismatch("quiet_window_ms", rsp_payload.quiet_window_ms,
                                  want.quiet_window_ms);
            end
         end
      end
      pending_count = expected_results.size();
   end

   initial begin
      error_count = 0;
      pending_count = 0;
      result_count = 0;
      finish_count = 0;
      timeout_count = 0;
   end

endmodule

`default_nettype wire

// ----- verif/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Drives the drain watchdog with directed and random begin, tick, poll and
// reset items under random idling and a long result hold-off; the checker
// beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module testbench;
   import tdw_pkg::*;

   localparam int RANDOM_ITEMS = 1000;
   localparam longint CYCLE_LIMIT = 1500000;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   req_type req_payload = '0;
   logic rsp_valid;
   logic rsp_stall = 0;
   rsp_type rsp_payload;
   logic csr_write_en = 0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   int error_count, pending_count, result_count, finish_count, timeout_count;
   longint cycle_count = 0;
   bit quiet_sides = 0;
   bit hold_results = 0;

   always #1 clock = ~clock;

   tx_drain_watchdog i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_payload(rsp_payload),
      .csr_write_en(csr_write_en), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   tdw_checker i_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_payload(rsp_payload),
      .csr_write_en(csr_write_en), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .error_count(error_count), .pending_count(pending_count),
      .result_count(result_count), .finish_count(finish_count),
      .timeout_count(timeout_count)
   );

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[tx_drain_watchdog] ERROR");
         $finish;
      end
   end

   // receiver stalls at random, or holds off fully when asked
   always @(negedge clock) begin
      if (hold_results) rsp_stall <= 1;
      else if (quiet_sides) rsp_stall <= 0;
      else rsp_stall <= ($urandom_range(99) < 19);
   end

   // one transfer on the request channel, with an optional idle gap first;
   // valid stays up for a following item and drops on an idle cycle
   task automatic send_item(input req_type r);
      if (!quiet_sides)
         while ($urandom_range(99) < 19) begin
            req_valid <= 0;
            @(negedge clock);
         end
      req_payload <= r;
      req_valid <= 1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic wait_idle();
      req_valid <= 0;
      while (pending_count != 0) @(negedge clock);
      repeat (60) @(negedge clock);
   endtask

   task automatic write_register(input logic [CSR_INDEX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] val);
      csr_index <= idx;
      csr_wdata <= val;
      csr_write_en <= 1;
      @(negedge clock);
      csr_write_en <= 0;
      @(negedge clock);
   endtask

   function automatic req_type make_item(input mode_type m, input logic [23:0] p,
                                         input logic [23:0] e, input logic [23:0] w,
                                         input logic [23:0] b, input logic s);
      req_type r;
      r.mode = m; r.pending_bytes = p; r.effective_bps = e; r.wire_bps = w;
      r.bytes_left = b; r.send_allowed = s;
      return r;
   endfunction

   function automatic logic [23:0] rand_value();
      case ($urandom_range(5))
         0: return $urandom_range(3);
         1: return $urandom_range(2000);
         2: return $urandom_range(100000);
         3: return 24'hffffff - $urandom_range(3);
         default: return $urandom;
      endcase
   endfunction

   // a drain: begin, then ticks, polls with non-growing residuals, resets and random items
   task automatic run_drain(input int steps);
      logic [23:0] left, p;
      req_type r;
      p = ($urandom_range(3) == 0) ? rand_value() : $urandom_range(3000);
      left = p;
      send_item(make_item(MODE_BEGIN, p, rand_value(), rand_value(), rand_value(),
                          $urandom));
      for (int i = 0; i < steps; i++) begin
         case ($urandom_range(9))
            0, 1, 2, 3: r = make_item(MODE_TICK, rand_value(), rand_value(), rand_value(),
                                      rand_value(), $urandom);
            4: r = make_item(MODE_RESET, rand_value(), rand_value(), rand_value(),
                             rand_value(), $urandom);
            5: r = make_item(mode_type'($urandom_range(3)), rand_value(), rand_value(),
                             rand_value(), rand_value(), $urandom);
            default: begin
               if ($urandom_range(2) == 0 && left > 0) left = left - $urandom_range(left);
               r = make_item(MODE_POLL, rand_value(), rand_value(), rand_value(), left,
                             $urandom_range(9) != 0);
            end
         endcase
         send_item(r);
      end
   endtask

   // tick run so the counters move past the windows
   task automatic tick_burst(input int n);
      for (int i = 0; i < n; i++)
         send_item(make_item(MODE_TICK, $urandom, $urandom, $urandom, $urandom, $urandom));
   endtask

   initial begin
      int sent, n;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      @(negedge clock);

      // directed: default registers, rate corner cases, extremes
      send_item(make_item(MODE_POLL, 0, 0, 0, 0, 1));
      send_item(make_item(MODE_BEGIN, 0, 0, 0, 0, 0));
      send_item(make_item(MODE_POLL, 0, 0, 0, 0, 1));
      send_item(make_item(MODE_BEGIN, 5000, 1, 0, 0, 0));
      send_item(make_item(MODE_BEGIN, 5000, 0, 100, 0, 0));
      send_item(make_item(MODE_BEGIN, 5000, 200, 0, 0, 0));
      send_item(make_item(MODE_BEGIN, 5000, 10, 8, 0, 0));
      send_item(make_item(MODE_BEGIN, 24'hffffff, 24'hffffff, 24'hffffff, 0, 0));
      send_item(make_item(MODE_BEGIN, 24'hffffff, 2, 2, 0, 0));
      send_item(make_item(MODE_BEGIN, 200, 1000, 9600, 0, 0));
      send_item(make_item(MODE_POLL, 0, 0, 0, 24'hffffff, 1));
      send_item(make_item(MODE_POLL, 0, 0, 0, 150, 0));
      send_item(make_item(MODE_POLL, 0, 0, 0, 0, 0));
      tick_burst(620);
      send_item(make_item(MODE_POLL, 0, 0, 0, 0, 1));
      send_item(make_item(MODE_RESET, 24'hffffff, 24'hffffff, 24'hffffff, 24'hffffff, 1));
      send_item(make_item(MODE_POLL, 0, 0, 0, 5, 1));
      wait_idle();

      // register extremes and mid values, each followed by random drains
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: begin write_register(CSR_DRAIN_TIMEOUT, 0);
                     write_register(CSR_DEBOUNCE, 0); end
            1: begin write_register(CSR_DRAIN_TIMEOUT, 600000);
                     write_register(CSR_DEBOUNCE, 1000); end
            2: begin write_register(CSR_DRAIN_TIMEOUT, 20'hfffff);
                     write_register(CSR_DEBOUNCE, 10'h3ff); end
            3: begin write_register(CSR_DRAIN_TIMEOUT, 3000);
                     write_register(CSR_DEBOUNCE, 30); end
            4: begin write_register(CSR_DRAIN_TIMEOUT, $urandom_range(20000));
                     write_register(CSR_DEBOUNCE, $urandom_range(1000)); end
            default: begin write_register(CSR_DRAIN_TIMEOUT, 8000);
                     write_register(CSR_DEBOUNCE, 50); end
         endcase
         quiet_sides = (phase == 3);
         sent = 0;
         while (sent < RANDOM_ITEMS / 6) begin
            run_drain(12);
            sent += 13;
            if ($urandom_range(7) == 0) begin
               n = $urandom_range(20, 100);
               tick_burst(n);
               sent += n;
            end
         end
         // one long result hold-off while requests keep coming
         if (phase == 2) begin
            fork
               begin
                  hold_results = 1;
                  repeat (300) @(negedge clock);
                  hold_results = 0;
               end
               run_drain(20);
            join
         end
         wait_idle();
      end

      // a large drain polled with a large residual after a short tick run
      write_register(CSR_DRAIN_TIMEOUT, 0);
      send_item(make_item(MODE_BEGIN, 50000, 0, 0, 0, 0));
      tick_burst(40);
      send_item(make_item(MODE_POLL, 0, 0, 0, 40000, 1));
      wait_idle();

      $display("covered %0d results, %0d finishes and %0d timeouts or stalls",
               result_count, finish_count, timeout_count);
      $display("under random idling, a long result hold-off and six register settings");
      if (error_count == 0) $display("[tx_drain_watchdog] OK");
      else $display("[tx_drain_watchdog] ERROR");
      $finish;
   end

endmodule

`default_nettype wire
